// ===== src/owtc_pkg.sv =====
// Shared types, codes and constants of the one-wire transaction controller.
// No dependencies; the engine, top level, checker and test import this package.
package owtc_pkg;

  localparam int BUFFER_BYTES_DEF = 16;
  localparam int ROM_BITS = 64;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [6:0] FORK_NONE = 7'h7F;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_XCHG    = 3'd1,
    OP_SEARCH  = 3'd2,
    OP_DONE    = 3'd3,
    OP_TICK    = 3'd4,
    OP_RD_RECV = 3'd5,
    OP_RD_ROM  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_RESET_END    = 3'd1,
    PH_XCHG_WRITE   = 3'd2,
    PH_XCHG_READ    = 3'd3,
    PH_SEARCH_WRITE = 3'd4,
    PH_SEARCH_ISSUE = 3'd5,
    PH_SEARCH_TRUE  = 3'd6,
    PH_SEARCH_COMP  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    JOB_IDLE       = 2'd0,
    JOB_EXCHANGE   = 2'd1,
    JOB_ROM_SEARCH = 2'd2
  } job_t;

  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_RESET  = 3'd1;
  localparam logic [2:0] CMD_WRITE  = 3'd2;
  localparam logic [2:0] CMD_PULLUP = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CRC      = 3'd1;
  localparam logic [2:0] ST_NO_PRES  = 3'd2;
  localparam logic [2:0] ST_NO_DEV   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] byte_index;
    logic [7:0] data;
    logic [4:0] send_length;
    logic [4:0] recv_length;
    logic [9:0] pullup_request_ms;
    logic       first_search;
    logic       bus_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bus_cmd;
    logic       bus_bit;
    logic [9:0] drive_pullup_ms;
    logic [2:0] status;
    logic       busy_res;
    logic       all_found;
    logic [7:0] read_data;
    logic [7:0] crc_value;
  } out_item_t;

endpackage

// ===== src/owtc_if.sv =====
// Valid/ready channel interfaces for the input and result words.
// Depends on nothing; widths follow the package field layout.
interface owtc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [3:0] byte_index;
  logic [7:0] data;
  logic [4:0] send_length;
  logic [4:0] recv_length;
  logic [9:0] pullup_request_ms;
  logic       first_search;
  logic       bus_value;
  modport source (output valid, opcode, byte_index, data, send_length, recv_length,
                  pullup_request_ms, first_search, bus_value, input ready);
  modport sink (input valid, opcode, byte_index, data, send_length, recv_length,
                pullup_request_ms, first_search, bus_value, output ready);
endinterface

interface owtc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_cmd;
  logic       bus_bit;
  logic [9:0] drive_pullup_ms;
  logic [2:0] status;
  logic       busy_res;
  logic       all_found;
  logic [7:0] read_data;
  logic [7:0] crc_value;
  modport source (output valid, bus_cmd, bus_bit, drive_pullup_ms, status, busy_res,
                  all_found, read_data, crc_value, input ready);
  modport sink (input valid, bus_cmd, bus_bit, drive_pullup_ms, status, busy_res,
                all_found, read_data, crc_value, output ready);
endinterface

// ===== src/owtc_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module owtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/owtc_engine.sv =====
// Transaction engine: control state, search and CRC logic, buffer read/modify/write.
// Depends on owtc_pkg; its buffers live in owtc_ram instances in the top level.
module owtc_engine import owtc_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int AW = BUFFER_BYTES > 1 ? $clog2(BUFFER_BYTES) : 1,
  localparam int LW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  in_item_t        item,
  input  logic [2:0]      next_opcode,
  input  logic [3:0]      next_index,
  input  logic [7:0]      send_q,
  input  logic [7:0]      recv_q,
  input  logic [15:0]     timeout_ms,
  output logic            send_we,
  output logic [AW-1:0]   send_waddr,
  output logic [7:0]      send_wdata,
  output logic [AW-1:0]   send_raddr,
  output logic            recv_we,
  output logic [AW-1:0]   recv_waddr,
  output logic [7:0]      recv_wdata,
  output logic [AW-1:0]   recv_raddr,
  output out_item_t       result
);

  logic [AW-1:0] idx_mod [16];

  for (genvar g = 0; g < 16; g++) begin : g_mod
    localparam int M = g % BUFFER_BYTES;
    assign idx_mod[g] = AW'(M);
  end

  phase_t      phase_r, phase_nxt;
  job_t        job_r, job_nxt;
  logic [LW-1:0] byte_pos_r, byte_pos_nxt;
  logic [2:0]  bit_pos_r, bit_pos_nxt;
  logic [63:0] rom_r, rom_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [6:0]  search_pos_r, search_pos_nxt;
  logic [6:0]  this_fork_r, this_fork_nxt;
  logic [6:0]  last_fork_r, last_fork_nxt;
  logic        true_bit_r, true_bit_nxt;
  logic        found_r, found_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [15:0] busy_ms_r, busy_ms_nxt;
  logic [LW-1:0] send_len_r, send_len_nxt;
  logic [LW-1:0] recv_len_r, recv_len_nxt;
  logic [9:0]  pullup_r, pullup_nxt;
  logic [7:0]  cmd_byte_r, cmd_byte_nxt;

  always_comb begin
    logic       go;
    logic       fb;
    logic       dir;
    logic [LW-1:0] slen;
    logic [LW-1:0] rlen;
    phase_nxt = phase_r;
    job_nxt = job_r;
    byte_pos_nxt = byte_pos_r;
    bit_pos_nxt = bit_pos_r;
    rom_nxt = rom_r;
    crc_nxt = crc_r;
    search_pos_nxt = search_pos_r;
    this_fork_nxt = this_fork_r;
    last_fork_nxt = last_fork_r;
    true_bit_nxt = true_bit_r;
    found_nxt = found_r;
    status_nxt = status_r;
    busy_ms_nxt = busy_ms_r;
    send_len_nxt = send_len_r;
    recv_len_nxt = recv_len_r;
    pullup_nxt = pullup_r;
    cmd_byte_nxt = cmd_byte_r;
    result = '0;
    send_we = 1'b0;
    send_waddr = idx_mod[item.byte_index];
    send_wdata = item.data;
    recv_we = 1'b0;
    recv_waddr = byte_pos_r[AW-1:0];
    recv_wdata = recv_q;
    go = 1'b0;
    fb = 1'b0;
    dir = 1'b0;
    slen = (LW'(item.send_length) > LW'(BUFFER_BYTES)) ? LW'(BUFFER_BYTES)
                                                       : LW'(item.send_length);
    rlen = (LW'(item.recv_length) > LW'(BUFFER_BYTES)) ? LW'(BUFFER_BYTES)
                                                       : LW'(item.recv_length);
    if (LW < 5) begin
      if (item.send_length > 5'(BUFFER_BYTES)) slen = LW'(BUFFER_BYTES);
      if (item.recv_length > 5'(BUFFER_BYTES)) rlen = LW'(BUFFER_BYTES);
    end
    if (fire) begin
      unique case (op_t'(item.opcode))
        OP_LOAD: begin
          send_we = 1'b1;
        end
        OP_XCHG: begin
          send_len_nxt = slen;
          recv_len_nxt = rlen;
          pullup_nxt = item.pullup_request_ms;
          job_nxt = JOB_EXCHANGE;
          phase_nxt = PH_RESET_END;
          busy_ms_nxt = '0;
          byte_pos_nxt = '0;
          bit_pos_nxt = '0;
          result.bus_cmd = CMD_RESET;
        end
        OP_SEARCH: begin
          if (item.first_search) begin
            found_nxt = 1'b0;
            last_fork_nxt = FORK_NONE;
            rom_nxt = '0;
          end
          this_fork_nxt = FORK_NONE;
          cmd_byte_nxt = item.data;
          send_len_nxt = LW'(1);
          recv_len_nxt = '0;
          pullup_nxt = '0;
          job_nxt = JOB_ROM_SEARCH;
          phase_nxt = PH_RESET_END;
          busy_ms_nxt = '0;
          byte_pos_nxt = '0;
          bit_pos_nxt = '0;
          result.bus_cmd = CMD_RESET;
        end
        OP_DONE: begin
          go = 1'b1;
          for (int k = 0; k < 3; k++) begin
            if (go) begin
              go = 1'b0;
              unique case (phase_nxt)
                PH_IDLE: begin
                end
                PH_RESET_END: begin
                  if (item.bus_value) begin
                    status_nxt = ST_NO_PRES;
                    phase_nxt = PH_IDLE;
                    busy_ms_nxt = '0;
                  end else begin
                    byte_pos_nxt = '0;
                    bit_pos_nxt = '0;
                    if (job_nxt == JOB_ROM_SEARCH) begin
                      phase_nxt = PH_SEARCH_WRITE;
                      go = 1'b1;
                    end else if (job_nxt == JOB_EXCHANGE) begin
                      phase_nxt = PH_XCHG_WRITE;
                      go = 1'b1;
                    end else begin
                      phase_nxt = PH_IDLE;
                      busy_ms_nxt = '0;
                    end
                  end
                end
                PH_XCHG_WRITE: begin
                  if (byte_pos_nxt < send_len_nxt) begin
                    result.bus_bit = send_q[bit_pos_nxt];
                    if (bit_pos_nxt == 3'd7) begin
                      bit_pos_nxt = '0;
                      byte_pos_nxt = byte_pos_nxt + LW'(1);
                    end else begin
                      bit_pos_nxt = bit_pos_nxt + 3'd1;
                    end
                    if (byte_pos_nxt < send_len_nxt) begin
                      result.bus_cmd = CMD_WRITE;
                    end else begin
                      result.bus_cmd = CMD_PULLUP;
                      result.drive_pullup_ms = pullup_nxt;
                    end
                  end else begin
                    byte_pos_nxt = '0;
                    bit_pos_nxt = '0;
                    if (recv_len_nxt != '0) begin
                      crc_nxt = '0;
                      result.bus_cmd = CMD_READ;
                      phase_nxt = PH_XCHG_READ;
                    end else begin
                      status_nxt = ST_OK;
                      phase_nxt = PH_IDLE;
                      busy_ms_nxt = '0;
                    end
                  end
                end
                PH_XCHG_READ: begin
                  fb = crc_nxt[7] ^ item.bus_value;
                  crc_nxt = {crc_nxt[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
                  recv_we = 1'b1;
                  recv_waddr = byte_pos_nxt[AW-1:0];
                  recv_wdata[bit_pos_nxt] = item.bus_value;
                  if (bit_pos_nxt == 3'd7) begin
                    bit_pos_nxt = '0;
                    byte_pos_nxt = byte_pos_nxt + LW'(1);
                  end else begin
                    bit_pos_nxt = bit_pos_nxt + 3'd1;
                  end
                  if (byte_pos_nxt < recv_len_nxt) begin
                    result.bus_cmd = CMD_READ;
                  end else begin
                    status_nxt = (crc_nxt != 8'h00) ? ST_CRC : ST_OK;
                    phase_nxt = PH_IDLE;
                    busy_ms_nxt = '0;
                  end
                end
                PH_SEARCH_WRITE: begin
                  if (byte_pos_nxt == '0) begin
                    result.bus_bit = cmd_byte_nxt[bit_pos_nxt];
                    if (bit_pos_nxt == 3'd7) begin
                      bit_pos_nxt = '0;
                      byte_pos_nxt = byte_pos_nxt + LW'(1);
                    end else begin
                      bit_pos_nxt = bit_pos_nxt + 3'd1;
                    end
                    result.bus_cmd = CMD_WRITE;
                  end else begin
                    search_pos_nxt = '0;
                    phase_nxt = PH_SEARCH_ISSUE;
                    go = 1'b1;
                  end
                end
                PH_SEARCH_ISSUE: begin
                  result.bus_cmd = CMD_READ;
                  phase_nxt = PH_SEARCH_TRUE;
                end
                PH_SEARCH_TRUE: begin
                  true_bit_nxt = item.bus_value;
                  result.bus_cmd = CMD_READ;
                  phase_nxt = PH_SEARCH_COMP;
                end
                PH_SEARCH_COMP: begin
                  if (true_bit_nxt && item.bus_value) begin
                    status_nxt = ST_NO_DEV;
                    phase_nxt = PH_IDLE;
                    busy_ms_nxt = '0;
                  end else begin
                    if (true_bit_nxt) begin
                      dir = 1'b1;
                    end else if (item.bus_value) begin
                      dir = 1'b0;
                    end else begin
                      if (last_fork_nxt != FORK_NONE && search_pos_nxt < last_fork_nxt) begin
                        dir = rom_nxt[search_pos_nxt[5:0]];
                      end else if (last_fork_nxt != FORK_NONE &&
                                   search_pos_nxt == last_fork_nxt) begin
                        dir = 1'b1;
                      end else begin
                        dir = 1'b0;
                      end
                      if (!dir) this_fork_nxt = search_pos_nxt;
                    end
                    rom_nxt[search_pos_nxt[5:0]] = dir;
                    result.bus_cmd = CMD_WRITE;
                    result.bus_bit = dir;
                    search_pos_nxt = search_pos_nxt + 7'd1;
                    if (search_pos_nxt < 7'(ROM_BITS)) begin
                      phase_nxt = PH_SEARCH_ISSUE;
                    end else begin
                      if (this_fork_nxt == FORK_NONE) found_nxt = 1'b1;
                      last_fork_nxt = this_fork_nxt;
                      status_nxt = ST_OK;
                      phase_nxt = PH_IDLE;
                      busy_ms_nxt = '0;
                    end
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        OP_TICK: begin
          if (phase_r == PH_IDLE) begin
            busy_ms_nxt = '0;
          end else begin
            if (busy_ms_r != 16'hFFFF) busy_ms_nxt = busy_ms_r + 16'd1;
            if (busy_ms_nxt > timeout_ms) begin
              phase_nxt = PH_IDLE;
              busy_ms_nxt = '0;
              job_nxt = JOB_IDLE;
              status_nxt = ST_TIMEOUT;
            end
          end
        end
        OP_RD_RECV: begin
          result.read_data = recv_q;
        end
        OP_RD_ROM: begin
          result.read_data = rom_r[{item.byte_index[2:0], 3'b000} +: 8];
        end
        default: begin
        end
      endcase
    end
    result.status = status_nxt;
    result.busy_res = (phase_nxt != PH_IDLE);
    result.all_found = found_nxt;
    result.crc_value = crc_nxt;
  end

  assign send_raddr = (phase_nxt == PH_RESET_END) ? '0 : byte_pos_nxt[AW-1:0];
  assign recv_raddr = (op_t'(next_opcode) == OP_RD_RECV) ? idx_mod[next_index]
                                                         : byte_pos_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      job_r <= JOB_IDLE;
      byte_pos_r <= '0;
      bit_pos_r <= '0;
      rom_r <= '0;
      crc_r <= '0;
      search_pos_r <= '0;
      this_fork_r <= FORK_NONE;
      last_fork_r <= FORK_NONE;
      true_bit_r <= 1'b0;
      found_r <= 1'b0;
      status_r <= ST_OK;
      busy_ms_r <= '0;
      send_len_r <= '0;
      recv_len_r <= '0;
      pullup_r <= '0;
      cmd_byte_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      job_r <= job_nxt;
      byte_pos_r <= byte_pos_nxt;
      bit_pos_r <= bit_pos_nxt;
      rom_r <= rom_nxt;
      crc_r <= crc_nxt;
      search_pos_r <= search_pos_nxt;
      this_fork_r <= this_fork_nxt;
      last_fork_r <= last_fork_nxt;
      true_bit_r <= true_bit_nxt;
      found_r <= found_nxt;
      status_r <= status_nxt;
      busy_ms_r <= busy_ms_nxt;
      send_len_r <= send_len_nxt;
      recv_len_r <= recv_len_nxt;
      pullup_r <= pullup_nxt;
      cmd_byte_r <= cmd_byte_nxt;
    end
  end

endmodule

// ===== src/one_wire_transaction_controller.sv =====
// Top level of the one-wire transaction controller: input stage, buffers, output register.
// Depends on owtc_pkg, owtc_if, owtc_ram and owtc_engine.
//
// Each input word (load, start exchange, start search, bus done, ms tick, reads)
// gives exactly one result word on out_ch, in order. A word accepted into the input
// stage has its buffer read launched as it is taken; the engine acts on it as it
// leaves the input stage, and its result is registered in the output register that
// drives out_ch.valid. While out_ch.ready stays high, one word a cycle is taken
// without a break, since the buffer read address is formed from the engine's next
// state and a write to the same entry in that cycle is forwarded to the reader.
// Configuration: cfg_we with cfg_wdata sets the busy timeout in milliseconds
// (5000 after reset); write it only while the block is idle.
// Reset (rst_n low at a clock edge) empties the pipeline and returns the
// engine to idle; the send and receive buffers keep their contents and are
// undefined until loaded. When out_ch.ready stays low, the result waits in the
// output register, one more word waits in the input stage, and in_ch.ready then
// drops until the receiver takes the waiting result.
module one_wire_transaction_controller import owtc_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  owtc_in_if.sink     in_ch,
  owtc_out_if.source  out_ch
);

  localparam int AW = BUFFER_BYTES > 1 ? $clog2(BUFFER_BYTES) : 1;

  logic        v1_r, v1_nxt;
  in_item_t    item_r;
  in_item_t    in_item;
  logic        vo_r, vo_nxt;
  out_item_t   res_r;
  out_item_t   result;
  logic [15:0] timeout_r;
  logic        s2_fire;
  logic        in_acc;

  logic          send_we, recv_we;
  logic [AW-1:0] send_waddr, send_raddr, recv_waddr, recv_raddr;
  logic [7:0]    send_wdata, recv_wdata, send_rdata, recv_rdata;
  logic          sfwd_r, rfwd_r;
  logic [7:0]    sfwd_data_r, rfwd_data_r;
  logic [7:0]    send_q, recv_q;

  assign in_item = '{opcode: in_ch.opcode, byte_index: in_ch.byte_index, data: in_ch.data,
                     send_length: in_ch.send_length, recv_length: in_ch.recv_length,
                     pullup_request_ms: in_ch.pullup_request_ms,
                     first_search: in_ch.first_search, bus_value: in_ch.bus_value};

  assign s2_fire = v1_r && (!vo_r || out_ch.ready);
  assign in_ch.ready = !v1_r || s2_fire;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign v1_nxt = in_acc ? 1'b1 : (s2_fire ? 1'b0 : v1_r);
  assign vo_nxt = s2_fire ? 1'b1 : (out_ch.ready ? 1'b0 : vo_r);

  assign send_q = sfwd_r ? sfwd_data_r : send_rdata;
  assign recv_q = rfwd_r ? rfwd_data_r : recv_rdata;

  owtc_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_send_ram (
    .clk(clk), .we(send_we), .waddr(send_waddr), .wdata(send_wdata),
    .re(in_acc), .raddr(send_raddr), .rdata(send_rdata)
  );

  owtc_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_recv_ram (
    .clk(clk), .we(recv_we), .waddr(recv_waddr), .wdata(recv_wdata),
    .re(in_acc), .raddr(recv_raddr), .rdata(recv_rdata)
  );

  owtc_engine #(.BUFFER_BYTES(BUFFER_BYTES)) u_engine (
    .clk(clk), .rst_n(rst_n), .fire(s2_fire), .item(item_r),
    .next_opcode(in_ch.opcode), .next_index(in_ch.byte_index),
    .send_q(send_q), .recv_q(recv_q), .timeout_ms(timeout_r),
    .send_we(send_we), .send_waddr(send_waddr), .send_wdata(send_wdata),
    .send_raddr(send_raddr),
    .recv_we(recv_we), .recv_waddr(recv_waddr), .recv_wdata(recv_wdata),
    .recv_raddr(recv_raddr), .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      vo_r <= 1'b0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      v1_r <= v1_nxt;
      vo_r <= vo_nxt;
      if (cfg_we) timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_item;
      sfwd_r <= send_we && (send_waddr == send_raddr);
      sfwd_data_r <= send_wdata;
      rfwd_r <= recv_we && (recv_waddr == recv_raddr);
      rfwd_data_r <= recv_wdata;
    end
    if (s2_fire) begin
      res_r <= result;
    end
  end

  assign out_ch.valid = vo_r;
  assign out_ch.bus_cmd = res_r.bus_cmd;
  assign out_ch.bus_bit = res_r.bus_bit;
  assign out_ch.drive_pullup_ms = res_r.drive_pullup_ms;
  assign out_ch.status = res_r.status;
  assign out_ch.busy_res = res_r.busy_res;
  assign out_ch.all_found = res_r.all_found;
  assign out_ch.read_data = res_r.read_data;
  assign out_ch.crc_value = res_r.crc_value;

endmodule

// ===== src/owtc_checker.sv =====
// Port-level checks of the one-wire transaction controller, bound to the top level.
// Depends on owtc_pkg for the bus command codes.
module owtc_checker import owtc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_bus_cmd,
  input logic       out_bus_bit,
  input logic [9:0] out_drive_pullup_ms,
  input logic       out_busy_res
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result word valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Stalled result word was dropped.");

  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_bus_cmd == CMD_RESET || out_bus_cmd == CMD_READ) |-> out_busy_res)
    else $error("Reset or read issued while not busy.");

  a_bit_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bus_bit |-> (out_bus_cmd == CMD_WRITE || out_bus_cmd == CMD_PULLUP))
    else $error("Write bit set without a write command.");

  a_pullup_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_drive_pullup_ms != 10'd0) |-> out_bus_cmd == CMD_PULLUP)
    else $error("Pull-up time given without a pull-up command.");

endmodule

bind one_wire_transaction_controller owtc_checker u_owtc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_bus_cmd(out_ch.bus_cmd),
  .out_bus_bit(out_ch.bus_bit),
  .out_drive_pullup_ms(out_ch.drive_pullup_ms),
  .out_busy_res(out_ch.busy_res)
);

// ===== sim/one_wire_transaction_controller_test.sv =====
// Self-checking test of the one-wire transaction controller: exchanges, ROM searches,
// timeouts and buffer reads are driven over valid/ready and checked against a predictor.
// Depends on owtc_pkg, owtc_if and the controller RTL.
`timescale 1ns / 1ps

module one_wire_transaction_controller_test;
  import owtc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] OP_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int errors = 0;
  int stall_cycles = 0;
  int sent = 0;

  owtc_in_if in_ch ();
  owtc_out_if out_ch ();

  one_wire_transaction_controller dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [15:0] timeout_ms;
  phase_t ph;
  job_t job;
  int bpos, bitp;
  logic [7:0] sbuf [16];
  logic [7:0] rbuf [16];
  logic [63:0] rom;
  logic [7:0] crc;
  int spos;
  logic [6:0] fork_now, fork_prev;
  logic tbit, found;
  logic [2:0] st;
  int busy_count;
  int slen, rlen;
  logic [9:0] pull;
  logic [7:0] cmd_byte;
  out_item_t expected_words [$];
  bit rbuf_written [16];

  task automatic model_reset();
    timeout_ms = TIMEOUT_RESET; ph = PH_IDLE; job = JOB_IDLE; bpos = 0; bitp = 0;
    rom = '0; crc = '0; spos = 0; fork_now = FORK_NONE; fork_prev = FORK_NONE;
    tbit = 0; found = 0; st = ST_OK; busy_count = 0; slen = 0; rlen = 0; pull = 0;
    cmd_byte = 0;
    for (int i = 0; i < 16; i++) begin
      sbuf[i] = 0; rbuf[i] = 0; rbuf_written[i] = 0;
    end
  endtask

  function automatic void next_bit();
    if (bitp >= 7) begin
      bitp = 0; bpos++;
    end else begin
      bitp++;
    end
  endfunction

  function automatic void run_bus_phase(input logic bv, inout out_item_t o, output bit more);
    int dir;
    logic fb;
    more = 0;
    case (ph)
      PH_RESET_END: begin
        if (bv) begin
          st = ST_NO_PRES; ph = PH_IDLE; busy_count = 0;
        end else begin
          bpos = 0; bitp = 0;
          if (job == JOB_ROM_SEARCH) begin
            ph = PH_SEARCH_WRITE; more = 1;
          end else if (job == JOB_EXCHANGE) begin
            ph = PH_XCHG_WRITE; more = 1;
          end else begin
            ph = PH_IDLE; busy_count = 0;
          end
        end
      end
      PH_XCHG_WRITE: begin
        if (bpos < slen) begin
          o.bus_bit = sbuf[bpos % 16][bitp];
          next_bit();
          if (bpos < slen) o.bus_cmd = CMD_WRITE;
          else begin
            o.bus_cmd = CMD_PULLUP; o.drive_pullup_ms = pull;
          end
        end else begin
          bpos = 0; bitp = 0;
          if (rlen > 0) begin
            crc = 0; o.bus_cmd = CMD_READ; ph = PH_XCHG_READ;
          end else begin
            st = ST_OK; ph = PH_IDLE; busy_count = 0;
          end
        end
      end
      PH_XCHG_READ: begin
        fb = crc[7] ^ bv;
        crc = {crc[6:0], 1'b0};
        if (fb) crc ^= CRC_POLY;
        rbuf[bpos % 16][bitp] = bv;
        if (bitp == 7) rbuf_written[bpos % 16] = 1;
        next_bit();
        if (bpos < rlen) o.bus_cmd = CMD_READ;
        else begin
          st = (crc != 0) ? ST_CRC : ST_OK; ph = PH_IDLE; busy_count = 0;
        end
      end
      PH_SEARCH_WRITE: begin
        if (bpos < 1) begin
          o.bus_bit = cmd_byte[bitp]; next_bit(); o.bus_cmd = CMD_WRITE;
        end else begin
          spos = 0; ph = PH_SEARCH_ISSUE; more = 1;
        end
      end
      PH_SEARCH_ISSUE: begin
        o.bus_cmd = CMD_READ; ph = PH_SEARCH_TRUE;
      end
      PH_SEARCH_TRUE: begin
        tbit = bv; o.bus_cmd = CMD_READ; ph = PH_SEARCH_COMP;
      end
      PH_SEARCH_COMP: begin
        if (tbit && bv) dir = 2;
        else if (tbit) dir = 1;
        else if (bv) dir = 0;
        else begin
          if (fork_prev != FORK_NONE && spos < fork_prev) dir = rom[spos];
          else if (fork_prev != FORK_NONE && spos == fork_prev) dir = 1;
          else dir = 0;
          if (dir == 0) fork_now = spos[6:0];
        end
        if (dir == 2) begin
          st = ST_NO_DEV; ph = PH_IDLE; busy_count = 0;
        end else begin
          rom[spos] = dir[0];
          o.bus_cmd = CMD_WRITE; o.bus_bit = dir[0];
          spos++;
          if (spos < ROM_BITS) ph = PH_SEARCH_ISSUE;
          else begin
            if (fork_now == FORK_NONE) found = 1;
            fork_prev = fork_now; st = ST_OK; ph = PH_IDLE; busy_count = 0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic out_item_t predict_controller(input in_item_t w);
    out_item_t o;
    bit more;
    o = '0;
    case (w.opcode)
      OP_LOAD: sbuf[w.byte_index] = w.data;
      OP_XCHG: begin
        slen = (w.send_length > 16) ? 16 : w.send_length;
        rlen = (w.recv_length > 16) ? 16 : w.recv_length;
        pull = w.pullup_request_ms;
        job = JOB_EXCHANGE; ph = PH_RESET_END; busy_count = 0; bpos = 0; bitp = 0;
        o.bus_cmd = CMD_RESET;
      end
      OP_SEARCH: begin
        if (w.first_search) begin
          found = 0; fork_prev = FORK_NONE; rom = '0;
        end
        fork_now = FORK_NONE; cmd_byte = w.data; slen = 1; rlen = 0; pull = 0;
        job = JOB_ROM_SEARCH; ph = PH_RESET_END; busy_count = 0; bpos = 0; bitp = 0;
        o.bus_cmd = CMD_RESET;
      end
      OP_DONE: begin
        for (int g = 0; g < 4; g++) begin
          if (ph == PH_IDLE) break;
          run_bus_phase(w.bus_value, o, more);
          if (!more) break;
        end
      end
      OP_TICK: begin
        if (ph == PH_IDLE) busy_count = 0;
        else begin
          if (busy_count < 16'hFFFF) busy_count++;
          if (busy_count > timeout_ms) begin
            ph = PH_IDLE; busy_count = 0; job = JOB_IDLE; st = ST_TIMEOUT;
          end
        end
      end
      OP_RD_RECV: o.read_data = rbuf[w.byte_index];
      OP_RD_ROM: o.read_data = rom[w.byte_index[2:0] * 8 +: 8];
      default: ;
    endcase
    o.status = st;
    o.busy_res = (ph != PH_IDLE);
    o.all_found = found;
    o.crc_value = crc;
    return o;
  endfunction

  task automatic send_word(input in_item_t w);
    if ($urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
        @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= w.opcode; in_ch.byte_index <= w.byte_index; in_ch.data <= w.data;
    in_ch.send_length <= w.send_length; in_ch.recv_length <= w.recv_length;
    in_ch.pullup_request_ms <= w.pullup_request_ms;
    in_ch.first_search <= w.first_search; in_ch.bus_value <= w.bus_value;
    do @(posedge clk); while (!in_ch.ready);
    expected_words.push_back(predict_controller(w));
    sent++;
  endtask

  function automatic in_item_t make_word(input logic [2:0] op, input logic [3:0] idx,
                                         input logic [7:0] d, input logic bv);
    in_item_t w;
    w = '0;
    w.opcode = op; w.byte_index = idx; w.data = d; w.bus_value = bv;
    w.send_length = 5'($urandom); w.recv_length = 5'($urandom);
    w.pullup_request_ms = 10'($urandom); w.first_search = 1'($urandom);
    return w;
  endfunction

  function automatic in_item_t random_word();
    in_item_t w;
    w.opcode = 3'($urandom); w.byte_index = 4'($urandom); w.data = 8'($urandom);
    w.send_length = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(17, 31)
                                                    : $urandom_range(0, 4));
    w.recv_length = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(0, 3));
    w.pullup_request_ms = 10'($urandom); w.first_search = 1'($urandom);
    w.bus_value = 1'($urandom);
    if (w.opcode == OP_SPARE) w.opcode = OP_DONE;
    if (w.opcode == OP_RD_RECV && !rbuf_written[w.byte_index]) w.opcode = OP_RD_ROM;
    return w;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_ms = v;
  endtask

  // Result side: random stalls and field-by-field compare.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with none expected"); errors++;
        end else begin
          out_item_t e;
          e = expected_words.pop_front();
          if (out_ch.bus_cmd !== e.bus_cmd) begin
            $error("bus_cmd exp %0d got %0d", e.bus_cmd, out_ch.bus_cmd); errors++;
          end
          if (out_ch.bus_bit !== e.bus_bit) begin
            $error("bus_bit exp %0d got %0d", e.bus_bit, out_ch.bus_bit); errors++;
          end
          if (out_ch.drive_pullup_ms !== e.drive_pullup_ms) begin
            $error("drive_pullup_ms exp %0d got %0d", e.drive_pullup_ms,
                   out_ch.drive_pullup_ms); errors++;
          end
          if (out_ch.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_ch.status); errors++;
          end
          if (out_ch.busy_res !== e.busy_res) begin
            $error("busy_res exp %0d got %0d", e.busy_res, out_ch.busy_res); errors++;
          end
          if (out_ch.all_found !== e.all_found) begin
            $error("all_found exp %0d got %0d", e.all_found, out_ch.all_found); errors++;
          end
          if (out_ch.read_data !== e.read_data) begin
            $error("read_data exp %0h got %0h", e.read_data, out_ch.read_data); errors++;
          end
          if (out_ch.crc_value !== e.crc_value) begin
            $error("crc_value exp %0h got %0h", e.crc_value, out_ch.crc_value); errors++;
          end
        end
      end
      if (stall_cycles > 0) begin
        stall_cycles <= stall_cycles - 1; out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_cycles <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                    : $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  int idle_count = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("one_wire_transaction_controller test failed");
      $finish;
    end
  end

  typedef struct {
    in_item_t w;
    bit check;
    out_item_t want;
  } directed_row_t;

  task automatic run_search(input logic first_pass, input int style);
    logic t, c;
    in_item_t w;
    w = make_word(OP_SEARCH, 4'($urandom), 8'hF0, 1'b0);
    w.first_search = first_pass;
    send_word(w);
    send_word(make_word(OP_DONE, 0, 0, ($urandom_range(0, 30) == 0)));
    for (int i = 0; i < 7; i++) send_word(make_word(OP_DONE, 0, 0, 1'($urandom)));
    for (int i = 0; i < 64 && ph != PH_IDLE; i++) begin
      if (style == 0) begin
        t = 1'($urandom); c = ($urandom_range(0, 3) == 0) ? 1'b0 : ~t;
      end else begin
        t = 1'($urandom); c = 1'($urandom);
      end
      if ($urandom_range(0, 150) == 0) send_word(make_word(OP_TICK, 0, 0, 0));
      send_word(make_word(OP_DONE, 0, 0, 1'b0));
      send_word(make_word(OP_DONE, 0, 0, t));
      send_word(make_word(OP_DONE, 0, 0, c));
    end
  endtask

  task automatic run_exchange();
    in_item_t w;
    int n;
    logic [3:0] idx;
    for (int i = 0; i < 4; i++)
      send_word(make_word(OP_LOAD, 4'($urandom), 8'($urandom), 1'b0));
    w = make_word(OP_XCHG, 0, 0, 0);
    w.send_length = 5'($urandom_range(0, 3)); w.recv_length = 5'($urandom_range(0, 3));
    if ($urandom_range(0, 15) == 0) w.recv_length = 5'($urandom_range(17, 31));
    send_word(w);
    send_word(make_word(OP_DONE, 0, 0, ($urandom_range(0, 15) == 0)));
    n = 8 * (w.send_length + (w.recv_length > 16 ? 16 : w.recv_length)) + 2;
    for (int i = 0; i < n && ph != PH_IDLE; i++) begin
      if ($urandom_range(0, 30) == 0) send_word(make_word(OP_TICK, 0, 0, 0));
      send_word(make_word(OP_DONE, 0, 0, 1'($urandom)));
    end
    for (int i = 0; i < 2; i++) begin
      idx = 4'($urandom);
      send_word(make_word(rbuf_written[idx] ? OP_RD_RECV : OP_RD_ROM, idx, 8'h00, 1'b0));
    end
  endtask

  initial begin
    directed_row_t rows [$];
    directed_row_t r;
    out_item_t got;
    in_ch.valid = 1'b0; in_ch.opcode = '0; in_ch.byte_index = '0; in_ch.data = '0;
    in_ch.send_length = '0; in_ch.recv_length = '0; in_ch.pullup_request_ms = '0;
    in_ch.first_search = 1'b0; in_ch.bus_value = 1'b0; out_ch.ready = 1'b0;
    model_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; a row with check set also compares against a typed-in result.
    r.check = 1; r.want = '0;
    r.w = make_word(OP_RD_ROM, 4'hF, 0, 0); rows.push_back(r);
    r.check = 0;
    for (int i = 0; i < 16; i++) begin
      r.w = make_word(OP_LOAD, 4'(i),
                      (i == 0) ? 8'h00 : (i == 15 ? 8'hFF : 8'(8'hA5 ^ i)), 1'b0);
      rows.push_back(r);
    end
    r.w = make_word(OP_XCHG, 0, 0, 0); r.w.send_length = 0; r.w.recv_length = 0;
    r.check = 1; r.want = '0; r.want.bus_cmd = CMD_RESET; r.want.busy_res = 1;
    rows.push_back(r);
    r.w = make_word(OP_DONE, 0, 0, 1); r.want = '0; r.want.status = ST_NO_PRES;
    rows.push_back(r);
    r.check = 0;
    r.w = make_word(OP_SPARE, 0, 0, 0); rows.push_back(r);
    r.w = make_word(OP_DONE, 0, 0, 0); rows.push_back(r);
    r.w = make_word(OP_XCHG, 0, 0, 0); r.w.send_length = 5'd31; r.w.recv_length = 5'd1;
    r.w.pullup_request_ms = 10'h3FF; rows.push_back(r);
    r.w = make_word(OP_SEARCH, 0, 8'hF0, 0); r.w.first_search = 1; rows.push_back(r);
    foreach (rows[i]) begin
      send_word(rows[i].w);
      got = expected_words[$];
      if (rows[i].check && got !== rows[i].want) begin
        $error("directed row %0d exp %h got %h", i, rows[i].want, got); errors++;
      end
    end
    drain();

    // Timeout extremes: 1 ms and the maximum, then a short one for the random part.
    write_timeout(16'd1);
    send_word(make_word(OP_TICK, 0, 0, 0));
    send_word(make_word(OP_TICK, 0, 0, 0));
    send_word(make_word(OP_TICK, 0, 0, 0));
    drain();
    write_timeout(16'hFFFF);
    send_word(make_word(OP_XCHG, 0, 0, 0));
    for (int i = 0; i < 3; i++) send_word(make_word(OP_TICK, 0, 0, 0));
    drain();
    write_timeout(16'd3);

    while (sent < 2000) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          run_search($urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
        end
        2, 3: begin
          run_exchange();
        end
        4: begin
          for (int i = 0; i < 30; i++) send_word(make_word(OP_TICK, 0, 0, 0));
        end
        default: begin
          for (int i = 0; i < 20; i++) send_word(random_word());
        end
      endcase
      if ($urandom_range(0, 4) == 0) begin
        drain();
        write_timeout($urandom_range(0, 1) ? 16'd5000 : 16'($urandom_range(1, 40)));
      end
    end
    drain();
    if (errors == 0) $display("one_wire_transaction_controller test passed");
    else $display("one_wire_transaction_controller test failed");
    $finish;
  end

endmodule

// ===== one_wire_transaction_controller.f =====
src/owtc_pkg.sv
src/owtc_if.sv
src/owtc_ram.sv
src/owtc_engine.sv
src/one_wire_transaction_controller.sv
src/owtc_checker.sv
sim/one_wire_transaction_controller_test.sv
